// ===== rtl/matrix_inverse_3x3_unit_macros.svh =====
// assertion macros for the checker file
`ifndef MATRIX_INVERSE_3X3_UNIT_MACROS_SVH
`define MATRIX_INVERSE_3X3_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MI3_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define MI3_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mi3_pkg.sv =====
// shared constants and index tables for the 3x3 inverse unit
`default_nettype none
package mi3_pkg;
	localparam int NUM_ELEM = 9;
	localparam int NUM_DET_TERMS = 3;
	localparam int THR_BITS = 31;

	typedef logic [3:0] elem_idx_t;

	// adjugate entry k = m[a]*m[b] - m[c]*m[d], columns a b c d
	localparam elem_idx_t COF_TAB [NUM_ELEM][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	// determinant expansion along row 0: m[e] * adj[a]
	localparam elem_idx_t DET_ELEM [NUM_DET_TERMS] = '{4'd0, 4'd1, 4'd2};
	localparam elem_idx_t DET_ADJ [NUM_DET_TERMS] = '{4'd0, 4'd3, 4'd6};

	// pipeline stage numbers
	localparam int ST_IN = 0;
	localparam int ST_PROD = 1;
	localparam int ST_ADJ = 2;
	localparam int ST_PART = 3;
	localparam int ST_TERM = 4;
	localparam int ST_DET = 5;
	localparam int ST_PREP = 6;
	localparam int ST_DIV = 7;
endpackage
`default_nettype wire

// ===== rtl/mi3_ifs.sv =====
// matrix and result channel interfaces
`default_nettype none
interface mi3_mat_if #(parameter int WORD_BITS = 32);
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface mi3_res_if #(parameter int WORD_BITS = 32);
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] inv00, inv01, inv02, inv10, inv11, inv12;
	logic signed [WORD_BITS-1:0] inv20, inv21, inv22, determinant;
	logic singular;
	logic saturated;

	modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, determinant, singular, saturated, input ready);
	modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, determinant, singular, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/mi3_div_lane.sv =====
// pipelined restoring divider lane, one quotient bit per stage
`default_nettype none
module mi3_div_lane #(
	parameter int QUOT_BITS = 32,
	parameter int DEN_BITS = 99,
	parameter int NUM_BITS = 97
) (
	input wire logic clk,
	input wire logic [QUOT_BITS:0] en,
	input wire logic [NUM_BITS-1:0] num,
	input wire logic [DEN_BITS-1:0] den,
	output logic [QUOT_BITS-1:0] quot,
	output logic ovf
);
	logic [DEN_BITS-1:0] rem_q [QUOT_BITS+1];
	logic [DEN_BITS-1:0] den_q [QUOT_BITS+1];
	logic [QUOT_BITS-1:0] sh_q [QUOT_BITS+1];
	logic [QUOT_BITS:0] ovf_q;
	logic [DEN_BITS-1:0] hi_ext;

	// quotient wider than QUOT_BITS means the word saturates anyway
	assign hi_ext = DEN_BITS'(num[NUM_BITS-1:QUOT_BITS]);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_q[0] <= hi_ext;
			den_q[0] <= den;
			sh_q[0] <= num[QUOT_BITS-1:0];
			ovf_q[0] <= hi_ext >= den;
		end
	end

	for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_step
		logic [DEN_BITS:0] trial;
		logic [DEN_BITS:0] diff;
		logic ge;

		assign trial = {rem_q[j-1], sh_q[j-1][QUOT_BITS-1]};
		assign diff = trial - {1'b0, den_q[j-1]};
		assign ge = trial >= {1'b0, den_q[j-1]};

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_q[j] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
				den_q[j] <= den_q[j-1];
				sh_q[j] <= {sh_q[j-1][QUOT_BITS-2:0], ge};
				ovf_q[j] <= ovf_q[j-1];
			end
		end
	end

	assign quot = sh_q[QUOT_BITS];
	assign ovf = ovf_q[QUOT_BITS];
endmodule
`default_nettype wire

// ===== rtl/matrix_inverse_3x3_unit.sv =====
// top level: pipelined 3x3 matrix inverse by the adjugate
//
// usage
//   req carries one matrix per word (nine signed fixed-point elements, row by row),
//   rsp carries the inverse, the truncated determinant, a singular flag and a
//   saturation flag. both are valid/ready channels; a word moves on a clock edge
//   with valid and ready high.
//   cfg_wr_en/cfg_wr_data write the singular threshold; write only when idle.
// throughput: one matrix per cycle while rsp does not stall; the restoring divider bank
//   (nine lanes, one quotient bit per stage) sets the depth.
// reset: arst_n clears every stage valid bit and sets the threshold to 1.
// stall: each stage holds while the one after it is full and blocked, so bubbles
//   collapse and req.ready stays high until every stage holds a word.
// FRAC_BITS must stay below WORD_BITS.
`default_nettype none
module matrix_inverse_3x3_unit #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [mi3_pkg::THR_BITS-1:0] cfg_wr_data,
	mi3_mat_if.sink req,
	mi3_res_if.source rsp
);
	import mi3_pkg::*;

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int PW = 2 * W;          // 2x2 product
	localparam int AW = 2 * W + 1;      // adjugate entry
	localparam int PLW = 2 * W + 2;     // element times low half of adjugate
	localparam int DETW = 3 * W + 3;    // exact determinant
	localparam int NUMW = AW + 2 * F;   // scaled adjugate magnitude
	localparam int TRW = DETW - 2 * F;  // truncated determinant magnitude
	localparam int CMPW = (TRW > THR_BITS) ? TRW : THR_BITS;
	localparam int NS = W + ST_DIV + 2;
	localparam int ST_OUT = NS - 1;

	localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};
	localparam logic [TRW-1:0] MAX_T = TRW'(MAX_W);
	localparam logic [TRW-1:0] MIN_T = TRW'(MIN_W);

	function automatic logic [AW-1:0] abs_adj(input logic [AW-1:0] v);
		return v[AW-1] ? (~v + AW'(1)) : v;
	endfunction

	// stage handshake: a stage loads when empty or when its content moves on
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;

	always_comb begin
		adv[ST_OUT] = !vld_q[ST_OUT] || rsp.ready;
		for (int k = ST_OUT - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~adv) | ({vld_q[NS-2:0], req.valid} & adv);
		end
	end

	assign req.ready = adv[ST_IN];
	assign rsp.valid = vld_q[ST_OUT];

	// singular threshold register
	logic [THR_BITS-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_BITS'(1);
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	logic signed [W-1:0] m_in [NUM_ELEM];

	assign m_in[0] = req.m00;
	assign m_in[1] = req.m01;
	assign m_in[2] = req.m02;
	assign m_in[3] = req.m10;
	assign m_in[4] = req.m11;
	assign m_in[5] = req.m12;
	assign m_in[6] = req.m20;
	assign m_in[7] = req.m21;
	assign m_in[8] = req.m22;

	logic signed [W-1:0] m_s1 [NUM_ELEM];
	logic signed [W-1:0] m_s2 [NUM_ELEM];
	logic signed [W-1:0] m_s3 [NUM_ELEM];
	logic signed [W-1:0] m_s4 [NUM_ELEM];
	logic signed [W-1:0] m_s5 [NUM_ELEM];
	logic signed [W-1:0] m_s6 [NUM_ELEM];
	logic signed [W-1:0] m_s7 [NUM_ELEM];
	logic [PW-1:0] pa_s2 [NUM_ELEM];
	logic [PW-1:0] pb_s2 [NUM_ELEM];
	logic [AW-1:0] adj_s3 [NUM_ELEM];
	logic [AW-1:0] adj_s4 [NUM_ELEM];
	logic [AW-1:0] adj_s5 [NUM_ELEM];
	logic [AW-1:0] adj_s6 [NUM_ELEM];
	logic [PLW-1:0] pl_s4 [NUM_DET_TERMS];
	logic [PW-1:0] ph_s4 [NUM_DET_TERMS];
	logic [DETW-1:0] term_s5 [NUM_DET_TERMS];
	logic [DETW-1:0] det_s6;
	logic det_neg_s7;
	logic det_zero_s7;
	logic [DETW-1:0] dmag_s7;
	logic [NUMW-1:0] num_s7 [NUM_ELEM];
	logic [NUM_ELEM-1:0] neg_s7;

	// input register
	always_ff @(posedge clk) begin
		if (adv[ST_IN]) begin
			m_s1 <= m_in;
		end
	end

	// the eighteen 2x2 products
	always_ff @(posedge clk) begin
		if (adv[ST_PROD]) begin
			m_s2 <= m_s1;
			for (int k = 0; k < NUM_ELEM; k++) begin
				pa_s2[k] <= $signed({{W{m_s1[COF_TAB[k][0]][W-1]}}, m_s1[COF_TAB[k][0]]})
					* $signed({{W{m_s1[COF_TAB[k][1]][W-1]}}, m_s1[COF_TAB[k][1]]});
				pb_s2[k] <= $signed({{W{m_s1[COF_TAB[k][2]][W-1]}}, m_s1[COF_TAB[k][2]]})
					* $signed({{W{m_s1[COF_TAB[k][3]][W-1]}}, m_s1[COF_TAB[k][3]]});
			end
		end
	end

	// adjugate entries, exact
	always_ff @(posedge clk) begin
		if (adv[ST_ADJ]) begin
			m_s3 <= m_s2;
			for (int k = 0; k < NUM_ELEM; k++) begin
				adj_s3[k] <= {pa_s2[k][PW-1], pa_s2[k]} - {pb_s2[k][PW-1], pb_s2[k]};
			end
		end
	end

	// determinant partial products, adjugate split into signed high and unsigned low
	always_ff @(posedge clk) begin
		if (adv[ST_PART]) begin
			m_s4 <= m_s3;
			adj_s4 <= adj_s3;
			for (int t = 0; t < NUM_DET_TERMS; t++) begin
				ph_s4[t] <= $signed({{W{m_s3[DET_ELEM[t]][W-1]}}, m_s3[DET_ELEM[t]]})
					* $signed({{W{adj_s3[DET_ADJ[t]][AW-1]}}, adj_s3[DET_ADJ[t]][AW-1:W+1]});
				pl_s4[t] <= $signed({{(W+2){m_s3[DET_ELEM[t]][W-1]}}, m_s3[DET_ELEM[t]]})
					* $signed({{(W+1){1'b0}}, adj_s3[DET_ADJ[t]][W:0]});
			end
		end
	end

	// recombine each determinant term
	always_ff @(posedge clk) begin
		if (adv[ST_TERM]) begin
			m_s5 <= m_s4;
			adj_s5 <= adj_s4;
			for (int t = 0; t < NUM_DET_TERMS; t++) begin
				term_s5[t] <= {{(DETW-PW-W-1){ph_s4[t][PW-1]}}, ph_s4[t], {(W+1){1'b0}}}
					+ {{(DETW-PLW){pl_s4[t][PLW-1]}}, pl_s4[t]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_DET]) begin
			m_s6 <= m_s5;
			adj_s6 <= adj_s5;
			det_s6 <= term_s5[0] + term_s5[1] + term_s5[2];
		end
	end

	// magnitudes and quotient signs for the divider bank
	always_ff @(posedge clk) begin
		if (adv[ST_PREP]) begin
			m_s7 <= m_s6;
			det_neg_s7 <= det_s6[DETW-1];
			det_zero_s7 <= det_s6 == '0;
			dmag_s7 <= det_s6[DETW-1] ? (~det_s6 + DETW'(1)) : det_s6;
			for (int k = 0; k < NUM_ELEM; k++) begin
				num_s7[k] <= {abs_adj(adj_s6[k]), {(2*F){1'b0}}};
				neg_s7[k] <= adj_s6[k][AW-1] ^ det_s6[DETW-1];
			end
		end
	end

	// determinant output and singular test, computed beside the divider's first stage
	logic [TRW-1:0] trunc;
	logic sing_c;
	logic sdet_c;
	logic [W-1:0] dout_c;

	always_comb begin
		trunc = dmag_s7[DETW-1:2*F];
		sing_c = det_zero_s7 || (CMPW'(trunc) < CMPW'(thr_q));
		sdet_c = det_neg_s7 ? (trunc > MIN_T) : (trunc > MAX_T);
		if (sdet_c) begin
			dout_c = det_neg_s7 ? MIN_W : MAX_W;
		end else begin
			dout_c = det_neg_s7 ? (~trunc[W-1:0] + W'(1)) : trunc[W-1:0];
		end
	end

	// side data traveling alongside the divider lanes
	logic signed [W-1:0] sd_m_q [W+1][NUM_ELEM];
	logic [NUM_ELEM-1:0] sd_neg_q [W+1];
	logic [W:0] sd_sing_q;
	logic [W:0] sd_sdet_q;
	logic [W-1:0] sd_dout_q [W+1];

	always_ff @(posedge clk) begin
		if (adv[ST_DIV]) begin
			sd_m_q[0] <= m_s7;
			sd_neg_q[0] <= neg_s7;
			sd_sing_q[0] <= sing_c;
			sd_sdet_q[0] <= sdet_c;
			sd_dout_q[0] <= dout_c;
		end
		for (int j = 1; j <= W; j++) begin
			if (adv[ST_DIV+j]) begin
				sd_m_q[j] <= sd_m_q[j-1];
				sd_neg_q[j] <= sd_neg_q[j-1];
				sd_sing_q[j] <= sd_sing_q[j-1];
				sd_sdet_q[j] <= sd_sdet_q[j-1];
				sd_dout_q[j] <= sd_dout_q[j-1];
			end
		end
	end

	// divider bank, one lane per adjugate entry
	logic [W-1:0] quot [NUM_ELEM];
	logic [NUM_ELEM-1:0] ovf;

	for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
		mi3_div_lane #(
			.QUOT_BITS(W),
			.DEN_BITS(DETW),
			.NUM_BITS(NUMW)
		) u_lane (
			.clk(clk),
			.en(adv[ST_DIV+W:ST_DIV]),
			.num(num_s7[k]),
			.den(dmag_s7),
			.quot(quot[k]),
			.ovf(ovf[k])
		);
	end

	// sign, saturation and singular select into the output register
	logic [W-1:0] inv_c [NUM_ELEM];
	logic [NUM_ELEM-1:0] qsat_c;

	always_comb begin
		for (int k = 0; k < NUM_ELEM; k++) begin
			qsat_c[k] = ovf[k] || (sd_neg_q[W][k] ? (quot[k] > MIN_W) : (quot[k] > MAX_W));
			if (sd_sing_q[W]) begin
				inv_c[k] = sd_m_q[W][k];
			end else if (qsat_c[k]) begin
				inv_c[k] = sd_neg_q[W][k] ? MIN_W : MAX_W;
			end else begin
				inv_c[k] = sd_neg_q[W][k] ? (~quot[k] + W'(1)) : quot[k];
			end
		end
	end

	logic [W-1:0] inv_q [NUM_ELEM];
	logic [W-1:0] det_q;
	logic sing_q;
	logic sat_q;

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			inv_q <= inv_c;
			det_q <= sd_dout_q[W];
			sing_q <= sd_sing_q[W];
			// a singular word echoes the input, so only the determinant can clip
			sat_q <= sd_sdet_q[W] || (!sd_sing_q[W] && (|qsat_c));
		end
	end

	assign rsp.inv00 = inv_q[0];
	assign rsp.inv01 = inv_q[1];
	assign rsp.inv02 = inv_q[2];
	assign rsp.inv10 = inv_q[3];
	assign rsp.inv11 = inv_q[4];
	assign rsp.inv12 = inv_q[5];
	assign rsp.inv20 = inv_q[6];
	assign rsp.inv21 = inv_q[7];
	assign rsp.inv22 = inv_q[8];
	assign rsp.determinant = det_q;
	assign rsp.singular = sing_q;
	assign rsp.saturated = sat_q;
endmodule
`default_nettype wire

// ===== rtl/mi3_checker.sv =====
// port-level checker for the 3x3 inverse unit, bound to the top level
`default_nettype none
`include "matrix_inverse_3x3_unit_macros.svh"
module mi3_checker #(
	parameter int WORD_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_singular,
	input wire logic out_saturated,
	input wire logic [10*WORD_BITS-1:0] out_word
);
	localparam int DEPTH = WORD_BITS + 9;
	localparam int CW = $clog2(DEPTH + 2);

	// words inside the pipeline
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(in_valid && in_ready) - CW'(out_valid && out_ready);
		end
	end

	`MI3_ASSERT_NOW(a_sing_no_sat, clk, arst_n, out_valid && out_singular, !out_saturated, "singular word flagged saturated")
	`MI3_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result changed")
	`MI3_ASSERT_NOW(a_depth, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "more words in flight than stages")
	`MI3_ASSERT_NOW(a_no_phantom, clk, arst_n, out_valid, cnt_q != '0, "result without an accepted matrix")
endmodule

bind matrix_inverse_3x3_unit mi3_checker #(.WORD_BITS(WORD_BITS)) u_mi3_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(req.valid),
	.in_ready(req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.out_singular(rsp.singular),
	.out_saturated(rsp.saturated),
	.out_word({rsp.inv00, rsp.inv01, rsp.inv02, rsp.inv10, rsp.inv11, rsp.inv12,
		rsp.inv20, rsp.inv21, rsp.inv22, rsp.determinant})
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the 3x3 matrix inverse unit: randomized stimulus, in-bench predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam int WB = 32;
	localparam int FB = 16;
	localparam int LATENCY = WB + 8;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [WB-1:0] word_t;
	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		word_t [8:0] m;
	} matrix_t;

	typedef struct packed {
		word_t [8:0] inv;
		word_t det;
		logic sing;
		logic sat;
	} inverse_t;

	// idling phases
	typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} idle_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [mi3_pkg::THR_BITS-1:0] cfg_wr_data = '0;

	mi3_mat_if #(.WORD_BITS(WB)) req ();
	mi3_res_if #(.WORD_BITS(WB)) rsp ();

	matrix_inverse_3x3_unit #(.WORD_BITS(WB), .FRAC_BITS(FB)) uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.req(req.sink), .rsp(rsp.source)
	);

	always #5 clk = ~clk;

	matrix_t pending_mats[$];
	inverse_t expected_inv[$];
	logic [30:0] threshold = 31'd1;
	idle_phase_t phase = PH_NONE;
	int errors = 0;
	longint cycles = 0;

	// saturate a wide signed value to the word range
	function automatic word_t clip_word(input wide_t v, inout logic sat);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (WB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			sat = 1'b1;
			return word_t'(hi);
		end
		if (v < lo) begin
			sat = 1'b1;
			return word_t'(lo);
		end
		return word_t'(v);
	endfunction

	// adjugate inverse with exact wide intermediates
	function automatic inverse_t invert_matrix(input matrix_t mt, input logic [30:0] thr);
		inverse_t r;
		wide_t m[9];
		wide_t adj[9];
		wide_t det, mag, num, q;
		logic sat;
		logic neg;
		sat = 1'b0;
		for (int i = 0; i < 9; i++) m[i] = wide_t'(mt.m[i]);
		adj[0] = m[4]*m[8] - m[5]*m[7];
		adj[1] = m[2]*m[7] - m[1]*m[8];
		adj[2] = m[1]*m[5] - m[2]*m[4];
		adj[3] = m[5]*m[6] - m[3]*m[8];
		adj[4] = m[0]*m[8] - m[2]*m[6];
		adj[5] = m[2]*m[3] - m[0]*m[5];
		adj[6] = m[3]*m[7] - m[4]*m[6];
		adj[7] = m[1]*m[6] - m[0]*m[7];
		adj[8] = m[0]*m[4] - m[1]*m[3];
		det = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
		mag = ((det < 0) ? -det : det) >>> (2 * FB);
		r.sing = (det == 0) || (mag < wide_t'({1'b0, thr}));
		r.det = clip_word((det < 0) ? -mag : mag, sat);
		for (int i = 0; i < 9; i++) begin
			if (r.sing) begin
				r.inv[i] = mt.m[i];
			end else begin
				neg = (adj[i] < 0) != (det < 0);
				num = ((adj[i] < 0) ? -adj[i] : adj[i]) <<< (2 * FB);
				q = num / ((det < 0) ? -det : det);
				r.inv[i] = clip_word(neg ? -q : q, sat);
			end
		end
		r.sat = sat;
		return r;
	endfunction

	// element drawn from a few magnitude classes
	function automatic word_t rand_elem();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom);
			1: return word_t'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
			2: return word_t'($signed($urandom_range(0, 32'h200)) - 32'sh100);
			3: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
			4: return '0;
			default: return word_t'($signed($urandom_range(0, 32'h40_0000)) - 32'sh20_0000);
		endcase
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t mt;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) mt.m[i] = rand_elem();
		// well-conditioned: diagonal-dominant small values
		if (kind < 5) begin
			for (int i = 0; i < 9; i++)
				mt.m[i] = word_t'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
			mt.m[0] = mt.m[0] + 32'sh4_0000;
			mt.m[4] = mt.m[4] - 32'sh4_0000;
			mt.m[8] = mt.m[8] + 32'sh4_0000;
		end else if (kind == 5) begin
			// rank deficient: row 2 copies row 0
			mt.m[6] = mt.m[0];
			mt.m[7] = mt.m[1];
			mt.m[8] = mt.m[2];
		end
		return mt;
	endfunction

	function automatic matrix_t diag(input word_t a, input word_t b, input word_t c);
		matrix_t mt;
		mt = '0;
		mt.m[0] = a;
		mt.m[4] = b;
		mt.m[8] = c;
		return mt;
	endfunction

	// driver: one word per handshake, gaps per phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			{req.m00, req.m01, req.m02, req.m10, req.m11, req.m12, req.m20, req.m21,
				req.m22} <= '0;
		end else begin
			cycles <= cycles + 1;
			if (!req.valid || req.ready) begin
				if (pending_mats.size() > 0 && !((phase == PH_SRC &&
						$urandom_range(0, 99) < 62) || (phase == PH_BOTH &&
						$urandom_range(0, 99) < 15))) begin
					matrix_t mt;
					mt = pending_mats.pop_front();
					expected_inv.push_back(invert_matrix(mt, threshold));
					req.valid <= 1'b1;
					{req.m22, req.m21, req.m20, req.m12, req.m11, req.m10, req.m02, req.m01,
						req.m00} <= mt;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else if (phase == PH_SNK)
			rsp.ready <= ($urandom_range(0, 99) >= 62);
		else if (phase == PH_BOTH)
			rsp.ready <= ($urandom_range(0, 99) >= 15);
		else
			rsp.ready <= 1'b1;
	end

	// monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			inverse_t got, exp_r;
			got.inv = {rsp.inv22, rsp.inv21, rsp.inv20, rsp.inv12, rsp.inv11, rsp.inv10,
				rsp.inv02, rsp.inv01, rsp.inv00};
			got.det = rsp.determinant;
			got.sing = rsp.singular;
			got.sat = rsp.saturated;
			if (expected_inv.size() == 0) begin
				errors++;
				$display("%0t unexpected word: actual %h", $time, got);
			end else begin
				exp_r = expected_inv.pop_front();
				for (int i = 0; i < 9; i++)
					if (got.inv[i] !== exp_r.inv[i]) begin
						errors++;
						$display("%0t inv[%0d] expected %h actual %h", $time, i,
							exp_r.inv[i], got.inv[i]);
					end
				if (got.det !== exp_r.det) begin
					errors++;
					$display("%0t determinant expected %h actual %h", $time, exp_r.det,
						got.det);
				end
				if (got.sing !== exp_r.sing || got.sat !== exp_r.sat) begin
					errors++;
					$display("%0t flags expected %b%b actual %b%b", $time, exp_r.sing,
						exp_r.sat, got.sing, got.sat);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// wait until the pipeline drains, then settle
	task automatic drain();
		while (pending_mats.size() > 0 || req.valid || expected_inv.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [30:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		threshold <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [30:0] thr_set[4];
		matrix_t mt;
		thr_set = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd3};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset threshold, identity, extremes, singular, saturation
		pending_mats.push_back(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
		pending_mats.push_back(diag(32'sh2_0000, -32'sh4_0000, 32'sh8000));
		pending_mats.push_back('0);
		pending_mats.push_back(diag(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		pending_mats.push_back(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		pending_mats.push_back(diag(32'sh1, 32'sh1, 32'sh1));
		pending_mats.push_back(diag(32'sh100, 32'sh100, 32'sh100));
		pending_mats.push_back(diag(32'sh1_0000, 32'sh1_0000, 32'sh1));
		mt = '1;
		pending_mats.push_back(mt);
		for (int i = 0; i < 9; i++) mt.m[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
		pending_mats.push_back(mt);
		for (int i = 0; i < 9; i++) mt.m[i] = word_t'(i + 1) <<< 16;
		pending_mats.push_back(mt);
		drain();

		// zero threshold with small but nonzero and exactly zero determinants
		write_threshold(31'd0);
		pending_mats.push_back(diag(32'sh1, 32'sh1, 32'sh1));
		pending_mats.push_back('0);
		pending_mats.push_back(diag(32'sh100, 32'sh100, 32'sh100));
		drain();

		// random phases across thresholds and idling patterns
		for (int p = 0; p < 8; p++) begin
			write_threshold((p == 7) ? 31'(($urandom) >> 1) : thr_set[p % 4]);
			phase = idle_phase_t'(p % 4);
			for (int k = 0; k < 125; k++) pending_mats.push_back(rand_matrix());
			drain();
		end

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
